/* src/irc_pkg.sv */
// ----------------------------------------------------------------------------
// irc_pkg
// shared types, constants and helpers of the set/clear interrupt controller
// ----------------------------------------------------------------------------
package irc_pkg;

    localparam int NUM_SOURCES         = 16;
    localparam int DELAY_WIDTH_DEFAULT = 16;

    localparam int CMD_W   = 2;
    localparam int VALUE_W = 16;
    localparam int INDEX_W = 4;
    localparam int TICKS_W = 16;
    localparam int REG_W   = 15;
    localparam int LEVEL_W = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE_REQUEST = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_ENABLE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SCHEDULE      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TICK          = 2'd3;

    // bit positions
    localparam int SETCLR_BIT    = 15;
    localparam int MASTER_EN_BIT = 14;
    localparam int TIMER_A_BIT   = 3;
    localparam int TIMER_B_BIT   = 13;

    // level groups, highest first
    localparam logic [REG_W-1:0] LEVEL6_MASK = 15'b110000000000000;
    localparam logic [REG_W-1:0] LEVEL5_MASK = 15'b001100000000000;
    localparam logic [REG_W-1:0] LEVEL4_MASK = 15'b000011110000000;
    localparam logic [REG_W-1:0] LEVEL3_MASK = 15'b000000001110000;
    localparam logic [REG_W-1:0] LEVEL2_MASK = 15'b000000000001000;
    localparam logic [REG_W-1:0] LEVEL1_MASK = 15'b000000000000111;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [VALUE_W-1:0] write_value;
        logic [INDEX_W-1:0] source_index;
        logic [TICKS_W-1:0] delay_ticks;
        logic               timer_a_irq_n;
        logic               timer_b_irq_n;
    } item_t;

    typedef struct packed {
        logic [REG_W-1:0]   request_bits;
        logic [REG_W-1:0]   enable_bits;
        logic [LEVEL_W-1:0] priority_level;
    } result_t;

    // cpu level from request and enable, gated by master enable
    function automatic logic [LEVEL_W-1:0] priority_of(input logic [REG_W-1:0] req,
                                                       input logic [REG_W-1:0] en);
        logic [REG_W-1:0]   m;
        logic [LEVEL_W-1:0] lvl;
        m = req & en;
        if (!en[MASTER_EN_BIT])           lvl = 3'd0;
        else if ((m & LEVEL6_MASK) != '0) lvl = 3'd6;
        else if ((m & LEVEL5_MASK) != '0) lvl = 3'd5;
        else if ((m & LEVEL4_MASK) != '0) lvl = 3'd4;
        else if ((m & LEVEL3_MASK) != '0) lvl = 3'd3;
        else if ((m & LEVEL2_MASK) != '0) lvl = 3'd2;
        else if ((m & LEVEL1_MASK) != '0) lvl = 3'd1;
        else                              lvl = 3'd0;
        return lvl;
    endfunction

endpackage

/* src/irc_stream_if.sv */
// ----------------------------------------------------------------------------
// irc_stream_if
// valid/ready channel carrying one payload per request
// ----------------------------------------------------------------------------
interface irc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* src/interrupt_request_controller.sv */
// ----------------------------------------------------------------------------
// interrupt_request_controller
// 16-source set/clear interrupt controller with per-source delayed requests
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                 request meaning
//  -------  ---  ----------------------  ----------------------------------
//  item     in   irc_pkg::item_t         register write, schedule or tick
//  result   out  irc_pkg::result_t       request, enable and cpu level
//
//  one request per cycle sustained while the result is taken; each request is
//  held in the input register, then written into the result register by the
//  single update stage between the two registers
//  rst_n clears the request/enable registers, all countdowns and valid bits
//  a held result stalls the update stage; item.ready drops only once the
//  input register is also full
//
module interrupt_request_controller #(
    parameter int DELAY_WIDTH = irc_pkg::DELAY_WIDTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    irc_stream_if.sink    item,
    irc_stream_if.source  result
);

    localparam int NUM_SRC = irc_pkg::NUM_SOURCES;
    localparam int REG_W   = irc_pkg::REG_W;
    // compare width for saturating the incoming delay
    localparam int CMP_W   = (DELAY_WIDTH > irc_pkg::TICKS_W) ? DELAY_WIDTH
                                                               : irc_pkg::TICKS_W;

    // input stage
    irc_pkg::item_t    s1_reg;
    logic              s1_valid_reg;

    // architectural state
    logic [REG_W-1:0]       request_reg,     request_next;
    logic [REG_W-1:0]       enable_reg,      enable_next;
    logic [NUM_SRC-1:0]     pend_valid_reg,  pend_valid_next;
    logic [DELAY_WIDTH-1:0] pend_cnt_reg  [NUM_SRC];
    logic [DELAY_WIDTH-1:0] pend_cnt_next [NUM_SRC];

    // result stage
    irc_pkg::result_t  out_reg;
    logic              out_valid_reg;

    logic               advance;
    logic [NUM_SRC-1:0] due_vec;
    logic [CMP_W-1:0]   delay_ext;
    logic [DELAY_WIDTH-1:0] delay_sat;

    // set/clear write: bit 15 picks set or clear, low bits are the mask
    function automatic logic [REG_W-1:0] set_clear(input logic [REG_W-1:0] cur,
                                                   input logic [irc_pkg::VALUE_W-1:0] wv);
        logic [REG_W-1:0] mask;
        mask = wv[REG_W-1:0];
        return wv[irc_pkg::SETCLR_BIT] ? (cur | mask) : (cur & ~mask);
    endfunction

    // active-low timer pins force their request bits
    function automatic logic [REG_W-1:0] apply_pins(input logic [REG_W-1:0] cur,
                                                    input logic a_n,
                                                    input logic b_n);
        logic [REG_W-1:0] r;
        r = cur;
        if (!a_n) r[irc_pkg::TIMER_A_BIT] = 1'b1;
        if (!b_n) r[irc_pkg::TIMER_B_BIT] = 1'b1;
        return r;
    endfunction

    // the update stage moves whenever the result slot is free or draining
    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;

    // delay saturated to the counter width
    assign delay_ext = CMP_W'(s1_reg.delay_ticks);
    assign delay_sat = (delay_ext > CMP_W'({DELAY_WIDTH{1'b1}}))
                       ? {DELAY_WIDTH{1'b1}} : delay_ext[DELAY_WIDTH-1:0];

    // a source is due on a tick when its count is already zero or one
    always_comb
    begin
        for (int i = 0; i < NUM_SRC; i++)
        begin
            due_vec[i] = pend_valid_reg[i] &&
                         (pend_cnt_reg[i] == '0 || pend_cnt_reg[i] == DELAY_WIDTH'(1));
        end
    end

    always_comb
    begin
        request_next    = request_reg;
        enable_next     = enable_reg;
        pend_valid_next = pend_valid_reg;
        pend_cnt_next   = pend_cnt_reg;
        if (advance)
        begin
            unique case (s1_reg.command)
                irc_pkg::CMD_WRITE_REQUEST:
                begin
                    request_next = apply_pins(set_clear(request_reg, s1_reg.write_value),
                                              s1_reg.timer_a_irq_n, s1_reg.timer_b_irq_n);
                end
                irc_pkg::CMD_WRITE_ENABLE:
                begin
                    enable_next = set_clear(enable_reg, s1_reg.write_value);
                end
                irc_pkg::CMD_SCHEDULE:
                begin
                    // keep only the earliest pending delay
                    if (!pend_valid_reg[s1_reg.source_index] ||
                        delay_sat < pend_cnt_reg[s1_reg.source_index])
                    begin
                        pend_cnt_next[s1_reg.source_index]   = delay_sat;
                        pend_valid_next[s1_reg.source_index] = 1'b1;
                    end
                end
                irc_pkg::CMD_TICK:
                begin
                    for (int i = 0; i < NUM_SRC; i++)
                    begin
                        if (pend_valid_reg[i] && pend_cnt_reg[i] != '0)
                            pend_cnt_next[i] = pend_cnt_reg[i] - DELAY_WIDTH'(1);
                        if (due_vec[i])
                            pend_valid_next[i] = 1'b0;
                    end
                    // source fifteen has no request bit, it only triggers the pins
                    if (due_vec != '0)
                        request_next = apply_pins(request_reg | due_vec[REG_W-1:0],
                                                  s1_reg.timer_a_irq_n,
                                                  s1_reg.timer_b_irq_n);
                end
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.valid && item.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            s1_reg <= item.payload;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_reg    <= '0;
            enable_reg     <= '0;
            pend_valid_reg <= '0;
            for (int i = 0; i < NUM_SRC; i++)
                pend_cnt_reg[i] <= '0;
        end
        else
        begin
            request_reg    <= request_next;
            enable_reg     <= enable_next;
            pend_valid_reg <= pend_valid_next;
            pend_cnt_reg   <= pend_cnt_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.request_bits   <= request_next;
            out_reg.enable_bits    <= enable_next;
            out_reg.priority_level <= irc_pkg::priority_of(request_next, enable_next);
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

`ifndef NO_ASSERTIONS
    // a nonzero level needs master enable in the same result
    a_level_gated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.priority_level != '0 |->
            out_reg.enable_bits[irc_pkg::MASTER_EN_BIT])
        else $error("priority level without master enable");

    // level never exceeds six
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.priority_level <= 3'd6)
        else $error("priority level out of range");

    // a tick retires every source that was due
    a_tick_retires: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_reg.command == irc_pkg::CMD_TICK |=>
            (pend_valid_reg & $past(due_vec)) == '0)
        else $error("due source still pending after tick");

    // a stalled input stage keeps its request
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_reg))
        else $error("input stage lost a stalled request");
`endif

endmodule
